// ===== sv/nscp_pkg.sv =====
// Shared constants and types for the nearest-speaker crossfade panner.
// Field widths, stream packing offsets and the speaker table request type.
// Depends on nothing; every other file refers to it, by scoped names or by import.
`default_nettype none

package nscp_pkg;

	// sizing
	localparam int TABLE_ENTRIES = 720;
	localparam int SAMPLE_BITS   = 24;
	localparam int TBL_ADDR_BITS = $clog2(TABLE_ENTRIES);

	// fixed field widths
	localparam int TI_BITS  = 10;
	localparam int SPK_BITS = 4;
	localparam int AZ_BITS  = 16;

	// gain format: Q1.16, 1.0 = 65536
	localparam int GAIN_FRAC = 16;
	localparam int GAIN_BITS = GAIN_FRAC + 1;
	localparam logic [GAIN_BITS-1:0] GAIN_ONE   = GAIN_BITS'(1) << GAIN_FRAC;
	localparam logic [GAIN_BITS-1:0] STEP_RESET = GAIN_BITS'(256);

	// azimuth to table index: ((az + 32768) * TABLE_ENTRIES + 32768) >> 16
	localparam int IDX_PROD_BITS = AZ_BITS + TBL_ADDR_BITS + 1;
	localparam int IDX_FULL_BITS = TBL_ADDR_BITS + 1;

	// sample times gain
	localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

	// slave tdata packing, lowest bit first
	localparam int IN_TI_LSB    = 0;
	localparam int IN_SPK_LSB   = IN_TI_LSB + TI_BITS;
	localparam int IN_AZ_LSB    = IN_SPK_LSB + SPK_BITS;
	localparam int IN_CS_LSB    = IN_AZ_LSB + AZ_BITS;
	localparam int IN_SMP_LSB   = IN_CS_LSB + 1;
	localparam int IN_USED_BITS = IN_SMP_LSB + SAMPLE_BITS;
	localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

	// master tdata packing, lowest bit first
	localparam int OUT_TSPK_LSB  = 0;
	localparam int OUT_TVAL_LSB  = OUT_TSPK_LSB + SPK_BITS;
	localparam int OUT_FSPK_LSB  = OUT_TVAL_LSB + SAMPLE_BITS;
	localparam int OUT_FVAL_LSB  = OUT_FSPK_LSB + SPK_BITS;
	localparam int OUT_USED_BITS = OUT_FVAL_LSB + SAMPLE_BITS;
	localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

	// tuser codes on the slave side
	typedef enum logic {
		KIND_TABLE_LOAD = 1'b0,
		KIND_SAMPLE     = 1'b1
	} kind_t;

	// one access to the speaker table
	typedef struct packed {
		logic                     we;
		logic                     re;
		logic [TBL_ADDR_BITS-1:0] addr;
		logic [SPK_BITS-1:0]      wdata;
	} tbl_req_t;

endpackage

`default_nettype wire

// ===== sv/nscp_table.sv =====
// Azimuth-to-speaker table: single-port memory with a registered read.
// Depends on nscp_pkg for sizes and the request struct.
`default_nettype none

module nscp_table (
	input  wire logic                         clk,
	input  wire nscp_pkg::tbl_req_t           req,
	output logic [nscp_pkg::SPK_BITS-1:0]     rd_data
);

	logic [nscp_pkg::SPK_BITS-1:0] mem [nscp_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/nearest_speaker_crossfade_panner_top.sv =====
// Nearest-speaker panner with a linear crossfade between chunks: top level.
// Depends on nscp_pkg and nscp_table.
//
// Usage:
//   Slave stream (s_*): one beat per item. s_tuser = 0 loads one entry of the
//   azimuth-to-speaker table, s_tuser = 1 carries an audio sample. A table load
//   gives no result; every sample gives exactly one master beat.
//   Master stream (m_*): the target speaker and its share of the sample, the
//   fading (previous) speaker and its share; m_tuser is high during a fade.
//   cfg_wen/cfg_wdata write ramp_step (Q1.16 gain increment per sample); write
//   it only while the block is idle.
// Pipeline: six registers (input, index, table read, chunk state, multiply,
//   output) lie between an accepted sample and m_tvalid. The block takes one
//   item per cycle unless a stall on m_tready holds the pipeline.
// The table is a 720 x 4 single-port memory; loads and reads both use it in
//   the same stage, so a load is seen by every later sample.
// Reset (arst_n low): drain the pipeline, clear chunk state and the ramp gain,
//   set ramp_step to 256. Table contents stay undefined until loaded.
// Stall: when m_tready is low the result holds; earlier stages keep filling
//   their bubbles, and s_tready drops only once every stage is occupied.
`default_nettype none

module nearest_speaker_crossfade_panner_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration
	input  wire logic                                   cfg_wen,
	input  wire logic [nscp_pkg::GAIN_BITS-1:0]         cfg_wdata,   // ramp_step
	// slave stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// table_index[9:0], table_speaker[13:10], azimuth[29:14], chunk_start[30],
	// sample_in[54:31], zero fill[55]
	input  wire logic [nscp_pkg::IN_DATA_BITS-1:0]      s_tdata,
	input  wire logic                                   s_tuser,     // kind
	// master stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// target_speaker[3:0], target_value[27:4], fade_speaker[31:28],
	// fade_value[55:32]
	output logic [nscp_pkg::OUT_DATA_BITS-1:0]          m_tdata,
	output logic                                        m_tuser      // fading
);

	localparam int SB  = nscp_pkg::SAMPLE_BITS;
	localparam int SPW = nscp_pkg::SPK_BITS;
	localparam int AW  = nscp_pkg::TBL_ADDR_BITS;
	localparam int GW  = nscp_pkg::GAIN_BITS;
	localparam int PW  = nscp_pkg::PROD_BITS;
	localparam int IPW = nscp_pkg::IDX_PROD_BITS;
	localparam int IFW = nscp_pkg::IDX_FULL_BITS;

	// ---------------- configuration ----------------
	logic [GW-1:0] ramp_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q <= nscp_pkg::STEP_RESET;
		end else if (cfg_wen) begin
			ramp_step_q <= cfg_wdata;
		end
	end

	// ---------------- pipeline flow control ----------------
	// A stage loads whenever it is empty or its content moves on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_out;

	assign adv_out = !m_tvalid || m_tready;
	assign adv_s5  = !v_s5 || adv_out;
	assign adv_s4  = !v_s4 || adv_s5;
	assign adv_s3  = !v_s3 || adv_s4;
	assign adv_s2  = !v_s2 || adv_s3;
	assign adv_s1  = !v_s1 || adv_s2;
	assign s_tready = adv_s1;

	// ---------------- stage 1: input register ----------------
	nscp_pkg::kind_t                 kind_s1;
	logic [nscp_pkg::TI_BITS-1:0]    ti_s1;
	logic [SPW-1:0]                  tspk_s1;
	logic [nscp_pkg::AZ_BITS-1:0]    az_s1;
	logic                            cs_s1;
	logic signed [SB-1:0]            smp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s1 <= nscp_pkg::kind_t'(s_tuser);
			ti_s1   <= s_tdata[nscp_pkg::IN_TI_LSB +: nscp_pkg::TI_BITS];
			tspk_s1 <= s_tdata[nscp_pkg::IN_SPK_LSB +: SPW];
			az_s1   <= s_tdata[nscp_pkg::IN_AZ_LSB +: nscp_pkg::AZ_BITS];
			cs_s1   <= s_tdata[nscp_pkg::IN_CS_LSB];
			smp_s1  <= s_tdata[nscp_pkg::IN_SMP_LSB +: SB];
		end
	end

	// ---------------- stage 2: table address ----------------
	// Offset the angle to unsigned, scale by the table size, round, wrap.
	logic [nscp_pkg::AZ_BITS-1:0] az_u;
	logic [IPW-1:0]               idx_prod;
	logic [IFW-1:0]               idx_full;
	logic [AW-1:0]                az_idx;
	logic                         ti_ok;

	assign az_u     = {~az_s1[nscp_pkg::AZ_BITS-1], az_s1[nscp_pkg::AZ_BITS-2:0]};
	assign idx_prod = IPW'(az_u) * IPW'(nscp_pkg::TABLE_ENTRIES)
	                + (IPW'(1) << (nscp_pkg::AZ_BITS - 1));
	assign idx_full = idx_prod[nscp_pkg::AZ_BITS +: IFW];
	assign az_idx   = (idx_full >= IFW'(nscp_pkg::TABLE_ENTRIES)) ? '0 : AW'(idx_full);
	assign ti_ok    = (32'(ti_s1) < 32'(nscp_pkg::TABLE_ENTRIES));

	nscp_pkg::kind_t      kind_s2;
	logic                 wr_ok_s2;
	logic [AW-1:0]        addr_s2;
	logic [SPW-1:0]       tspk_s2;
	logic                 cs_s2;
	logic signed [SB-1:0] smp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			kind_s2  <= kind_s1;
			wr_ok_s2 <= ti_ok;
			addr_s2  <= (kind_s1 == nscp_pkg::KIND_SAMPLE) ? az_idx : AW'(ti_s1);
			tspk_s2  <= tspk_s1;
			cs_s2    <= cs_s1;
			smp_s2   <= smp_s1;
		end
	end

	// ---------------- stage 3: table access ----------------
	// Loads end here, writing if in range; samples on a chunk start read the table.
	nscp_pkg::tbl_req_t tbl_req;
	logic [SPW-1:0]     tbl_rd;

	always_comb begin
		tbl_req.we    = v_s2 && adv_s3 && (kind_s2 == nscp_pkg::KIND_TABLE_LOAD) && wr_ok_s2;
		tbl_req.re    = v_s2 && adv_s3 && (kind_s2 == nscp_pkg::KIND_SAMPLE) && cs_s2;
		tbl_req.addr  = addr_s2;
		tbl_req.wdata = tspk_s2;
	end

	nscp_table u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_data (tbl_rd)
	);

	logic                 cs_s3;
	logic signed [SB-1:0] smp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2 && (kind_s2 == nscp_pkg::KIND_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			cs_s3  <= cs_s2;
			smp_s3 <= smp_s2;
		end
	end

	// ---------------- stage 4: chunk state and ramp ----------------
	logic [SPW-1:0] last_spk_q, chunk_spk_q, from_spk_q;
	logic           xfade_q;
	logic [GW-1:0]  gain_q;

	logic [SPW-1:0] spk_nx, from_nx;
	logic           xfade_nx;
	logic [GW-1:0]  gain_base, gain_nx;
	logic [GW:0]    gain_sum;

	assign spk_nx    = cs_s3 ? tbl_rd : chunk_spk_q;
	assign from_nx   = cs_s3 ? last_spk_q : from_spk_q;
	assign xfade_nx  = cs_s3 ? (tbl_rd != last_spk_q) : xfade_q;
	assign gain_base = cs_s3 ? '0 : gain_q;
	assign gain_sum  = {1'b0, gain_base} + {1'b0, ramp_step_q};
	assign gain_nx   = (gain_sum > {1'b0, nscp_pkg::GAIN_ONE}) ? nscp_pkg::GAIN_ONE
	                                                          : gain_sum[GW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_spk_q  <= '0;
			chunk_spk_q <= '0;
			from_spk_q  <= '0;
			xfade_q     <= 1'b0;
			gain_q      <= '0;
		end else if (v_s3 && adv_s4) begin
			last_spk_q  <= spk_nx;
			chunk_spk_q <= spk_nx;
			from_spk_q  <= from_nx;
			xfade_q     <= xfade_nx;
			gain_q      <= xfade_nx ? gain_nx : '0;
		end
	end

	// Outside a fade the gain is 1.0, so the split below passes the sample whole.
	logic [SPW-1:0]       spk_s4, fspk_s4;
	logic                 fading_s4;
	logic [GW-1:0]        gain_s4;
	logic signed [SB-1:0] smp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			spk_s4    <= spk_nx;
			fspk_s4   <= xfade_nx ? from_nx : '0;
			fading_s4 <= xfade_nx;
			gain_s4   <= xfade_nx ? gain_nx : nscp_pkg::GAIN_ONE;
			smp_s4    <= smp_s3;
		end
	end

	// ---------------- stage 5: sample times gain ----------------
	logic signed [PW-1:0] prod_s5;
	logic [SPW-1:0]       spk_s5, fspk_s5;
	logic                 fading_s5;
	logic signed [SB-1:0] smp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			prod_s5   <= PW'(smp_s4) * PW'($signed({1'b0, gain_s4}));
			spk_s5    <= spk_s4;
			fspk_s5   <= fspk_s4;
			fading_s5 <= fading_s4;
			smp_s5    <= smp_s4;
		end
	end

	// ---------------- output register ----------------
	// Round half up, then give the remainder to the fading speaker.
	logic signed [PW-1:0] prod_rnd;
	logic signed [SB-1:0] tval, fval;

	assign prod_rnd = prod_s5 + (PW'(1) << (nscp_pkg::GAIN_FRAC - 1));
	assign tval     = prod_rnd[nscp_pkg::GAIN_FRAC +: SB];
	assign fval     = smp_s5 - tval;

	logic [SPW-1:0]       tspk_q, fspk_q;
	logic signed [SB-1:0] tval_q, fval_q;
	logic                 fading_q;
	logic                 out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_out) begin
			out_v_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			tspk_q   <= spk_s5;
			tval_q   <= tval;
			fspk_q   <= fspk_s5;
			fval_q   <= fval;
			fading_q <= fading_s5;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = fading_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[nscp_pkg::OUT_TSPK_LSB +: SPW] = tspk_q;
		m_tdata[nscp_pkg::OUT_TVAL_LSB +: SB]  = tval_q;
		m_tdata[nscp_pkg::OUT_FSPK_LSB +: SPW] = fspk_q;
		m_tdata[nscp_pkg::OUT_FVAL_LSB +: SB]  = fval_q;
	end

endmodule

`default_nettype wire

// ===== sv/nscp_checker.sv =====
// Port-level checks for the nearest-speaker crossfade panner, bound to the top.
// Depends on nscp_pkg for the master tdata layout.
`default_nettype none

module nscp_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tready,
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [nscp_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input  wire logic                                m_tuser
);

	logic [nscp_pkg::SPK_BITS-1:0]    tspk, fspk;
	logic [nscp_pkg::SAMPLE_BITS-1:0] fval;

	assign tspk = m_tdata[nscp_pkg::OUT_TSPK_LSB +: nscp_pkg::SPK_BITS];
	assign fspk = m_tdata[nscp_pkg::OUT_FSPK_LSB +: nscp_pkg::SPK_BITS];
	assign fval = m_tdata[nscp_pkg::OUT_FVAL_LSB +: nscp_pkg::SAMPLE_BITS];

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// without a fade the whole sample goes to the target speaker
	a_no_fade: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> fval == '0 && fspk == '0)
		else $error("fade share outside a crossfade");

	// a fade only runs between two different speakers
	a_fade_spk: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> fspk != tspk)
		else $error("crossfade to the same speaker");

	// with the output stage empty the pipeline cannot be full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind nearest_speaker_crossfade_panner_top nscp_checker u_nscp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== bench/pan_checker.sv =====
// Scoreboard for the nearest-speaker crossfade panner: watches the config port
// and both streams, predicts each sample's speaker split and compares it.
// Depends on nscp_pkg for field widths, packing offsets and the kind codes.

module pan_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [nscp_pkg::GAIN_BITS-1:0]      cfg_wdata,
	input  wire logic                                s_tvalid,
	input  wire logic                                s_tready,
	input  wire logic [nscp_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input  wire logic                                s_tuser,
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [nscp_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input  wire logic                                m_tuser,
	output int                                       mismatches,
	output int                                       awaited,
	output int                                       fade_beats
);
	timeunit 1ns;
	timeprecision 1ps;
	import nscp_pkg::*;

	typedef struct {
		logic [SPK_BITS-1:0]    tspk;
		logic [SAMPLE_BITS-1:0] tval;
		logic [SPK_BITS-1:0]    fspk;
		logic [SAMPLE_BITS-1:0] fval;
		logic                   fading;
	} pan_split_t;

	logic [SPK_BITS-1:0]  spk_map [TABLE_ENTRIES];
	logic [SPK_BITS-1:0]  prev_spk = '0;
	logic [SPK_BITS-1:0]  cur_spk  = '0;
	logic [SPK_BITS-1:0]  old_spk  = '0;
	logic                 fading_now = 1'b0;
	logic [GAIN_BITS-1:0] gain = '0;
	logic [GAIN_BITS-1:0] step = STEP_RESET;
	pan_split_t           expected_splits [$];
	int                   errs  = 0;
	int                   nfade = 0;

	initial begin
		mismatches = 0;
		awaited    = 0;
		fade_beats = 0;
	end

	// Work out the split for one accepted sample beat and queue it.
	task automatic split_sample(input logic [IN_DATA_BITS-1:0] d);
		logic signed [AZ_BITS-1:0] az;
		longint                    idx;
		logic [GAIN_BITS:0]        g;
		longint                    smp;
		longint                    tgt;
		pan_split_t                r;
		begin
			if (d[IN_CS_LSB]) begin
				az  = d[IN_AZ_LSB +: AZ_BITS];
				idx = ((longint'(az) + 32768) * TABLE_ENTRIES + 32768) >> 16;
				if (idx >= TABLE_ENTRIES)
					idx = 0;
				cur_spk    = spk_map[idx];
				fading_now = (cur_spk != prev_spk);
				old_spk    = prev_spk;
				prev_spk   = cur_spk;
				gain       = '0;
			end
			smp    = longint'($signed(d[IN_SMP_LSB +: SAMPLE_BITS]));
			r.tspk = cur_spk;
			if (fading_now) begin
				g = {1'b0, gain} + {1'b0, step};
				if (g > {1'b0, GAIN_ONE})
					g = {1'b0, GAIN_ONE};
				gain     = g[GAIN_BITS-1:0];
				// round half up: add half, then arithmetic shift of the signed product
				tgt      = (smp * longint'(g) + 32768) >>> GAIN_FRAC;
				r.tval   = SAMPLE_BITS'(tgt);
				r.fspk   = old_spk;
				r.fval   = SAMPLE_BITS'(smp - tgt);
				r.fading = 1'b1;
			end else begin
				r.tval   = SAMPLE_BITS'(smp);
				r.fspk   = '0;
				r.fval   = '0;
				r.fading = 1'b0;
			end
			expected_splits.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		begin
			if (want != got) begin
				errs++;
				$display("time %0t: %s mismatch, expected %0d, got %0d",
					$time, name, want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pan_split_t want;
		if (!arst_n) begin
			prev_spk   = '0;
			cur_spk    = '0;
			old_spk    = '0;
			fading_now = 1'b0;
			gain       = '0;
			step       = STEP_RESET;
			expected_splits.delete();
			awaited <= 0;
		end else begin
			if (cfg_wen)
				step = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_TABLE_LOAD) begin
					if (s_tdata[IN_TI_LSB +: TI_BITS] < TABLE_ENTRIES)
						spk_map[s_tdata[IN_TI_LSB +: TI_BITS]] =
							s_tdata[IN_SPK_LSB +: SPK_BITS];
				end else begin
					split_sample(s_tdata);
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_splits.size() == 0) begin
					errs++;
					$display("time %0t: result beat with none expected, expected none, got %h",
						$time, m_tdata);
				end else begin
					want = expected_splits.pop_front();
					if (m_tuser)
						nfade++;
					check_field("target_speaker", want.tspk,
						m_tdata[OUT_TSPK_LSB +: SPK_BITS]);
					check_field("target_value", longint'($signed(want.tval)),
						longint'($signed(m_tdata[OUT_TVAL_LSB +: SAMPLE_BITS])));
					check_field("fade_speaker", want.fspk,
						m_tdata[OUT_FSPK_LSB +: SPK_BITS]);
					check_field("fade_value", longint'($signed(want.fval)),
						longint'($signed(m_tdata[OUT_FVAL_LSB +: SAMPLE_BITS])));
					check_field("fading", want.fading, m_tuser);
				end
			end
			awaited <= expected_splits.size();
		end
		mismatches <= errs;
		fade_beats <= nfade;
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the panner bench: clock, reset, stimulus and the verdict.
// Depends on nscp_pkg, nearest_speaker_crossfade_panner_top and pan_checker.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nscp_pkg::*;

	localparam int PHASES          = 9;
	localparam int ITEMS_PER_PHASE = 165;
	// slack after the last result for the pipeline to drain trailing table loads
	localparam int SETTLE_CYCLES   = 12;
	localparam int U_FULL          = 65535;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_wen   = 1'b0;
	logic [GAIN_BITS-1:0]      cfg_wdata = '0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [IN_DATA_BITS-1:0]   s_tdata   = '0;
	logic                      s_tuser   = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [OUT_DATA_BITS-1:0]  m_tdata;
	logic                      m_tuser;

	int mismatches;
	int awaited;
	int fade_beats;

	// idle odds in percent for each side, changed every third phase
	int send_idle_pct = 6;
	int recv_idle_pct = 49;

	// bookkeeping for stimulus and the summary
	bit written [TABLE_ENTRIES];
	int loaded_idx [$];
	int items_sent   = 0;
	int n_loads      = 0;
	int n_stray      = 0;
	int n_samples    = 0;
	int n_chunks     = 0;
	int n_settings   = 0;

	always #5 clk = ~clk;

	nearest_speaker_crossfade_panner_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	pan_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.awaited    (awaited),
		.fade_beats (fade_beats)
	);

	// Receiver: roll the ready line every cycle against the current odds.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Lowest offset (azimuth + 32768) that rounds to table position w.
	// w equal to the table size gives the start of the wrap-around band.
	function automatic int offset_for_index(input int w);
		int n;
		begin
			n = w * 65536 - 32768 + (TABLE_ENTRIES - 1);
			return (n < 0) ? 0 : n / TABLE_ENTRIES;
		end
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(15))
			0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};   // full scale positive
			1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};   // full scale negative
			2:       return '0;
			3:       return '1;                                 // minus one LSB
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [IN_DATA_BITS-1:0] pack_item(
		input logic [TI_BITS-1:0]     ti,
		input logic [SPK_BITS-1:0]    spk,
		input logic [AZ_BITS-1:0]     az,
		input logic                   cs,
		input logic [SAMPLE_BITS-1:0] smp
	);
		logic [IN_DATA_BITS-1:0] d;
		begin
			d = '0;
			d[IN_TI_LSB  +: TI_BITS]     = ti;
			d[IN_SPK_LSB +: SPK_BITS]    = spk;
			d[IN_AZ_LSB  +: AZ_BITS]     = az;
			d[IN_CS_LSB]                 = cs;
			d[IN_SMP_LSB +: SAMPLE_BITS] = smp;
			return d;
		end
	endfunction

	// Present one beat and hold it until the handshake completes. Idle cycles
	// go in front of the beat; valid is never dropped and raised in one step.
	task automatic send_beat(input logic [IN_DATA_BITS-1:0] d, input logic kind);
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= d;
			s_tuser  <= kind;
			do
				@(posedge clk);
			while (!s_tready);
		end
	endtask

	// Table load; the sample-side fields carry junk the block must ignore.
	task automatic load_entry(input int idx, input logic [SPK_BITS-1:0] spk);
		begin
			send_beat(pack_item(TI_BITS'(idx), spk, AZ_BITS'($urandom), 1'($urandom),
				SAMPLE_BITS'($urandom)), KIND_TABLE_LOAD);
			if (idx < TABLE_ENTRIES) begin
				if (!written[idx]) begin
					written[idx] = 1'b1;
					loaded_idx.push_back(idx);
				end
				n_loads++;
				items_sent++;
			end else begin
				n_stray++;
			end
		end
	endtask

	// Audio sample; the table-load fields carry junk the block must ignore.
	task automatic play_sample(input logic cs, input logic [AZ_BITS-1:0] az,
			input logic [SAMPLE_BITS-1:0] smp);
		begin
			send_beat(pack_item(TI_BITS'($urandom), SPK_BITS'($urandom), az, cs, smp),
				KIND_SAMPLE);
			n_samples++;
			items_sent++;
			if (cs)
				n_chunks++;
		end
	endtask

	// Hold off until every predicted result has come back and the pipeline
	// has had time to swallow any trailing table loads.
	task automatic drain();
		begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (awaited != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	task automatic write_ramp(input logic [GAIN_BITS-1:0] v);
		begin
			drain();
			cfg_wen   <= 1'b1;
			cfg_wdata <= v;
			@(posedge clk);
			cfg_wen   <= 1'b0;
			n_settings++;
		end
	endtask

	// Ramp plan: the legal extremes, the out-of-spec zero and oversize values,
	// and a few ordinary chunk lengths in between.
	function automatic logic [GAIN_BITS-1:0] ramp_for_phase(input int p);
		case (p)
			0:       return GAIN_ONE;
			1:       return GAIN_BITS'(1);
			2:       return '0;
			3:       return '1;
			4:       return GAIN_BITS'(4096);
			5:       return STEP_RESET;
			6:       return GAIN_ONE + GAIN_BITS'(1);
			7:       return GAIN_BITS'(2048);
			default: return GAIN_BITS'($urandom_range(65536, 1));
		endcase
	endfunction

	function automatic void set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 6;  recv_idle_pct = 49; end
			1: begin send_idle_pct = 49; recv_idle_pct = 6;  end
			default: begin send_idle_pct = 0; recv_idle_pct = 0; end
		endcase
	endfunction

	initial begin
		int                p;
		int                stop_at;
		int                len;
		int                w;
		int                lo;
		int                hi;
		logic [AZ_BITS-1:0] az;
		logic [AZ_BITS-1:0] last_az;

		set_idling(0);
		last_az = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: samples ahead of any chunk start go to speaker 0 unfaded,
		// at both full-scale ends, under the reset ramp step.
		play_sample(1'b0, 16'h1234, {1'b0, {(SAMPLE_BITS-1){1'b1}}});
		play_sample(1'b0, 16'hFEDC, {1'b1, {(SAMPLE_BITS-1){1'b0}}});
		// table corners and center, plus loads past the end that must vanish
		load_entry(0, 4'd5);
		load_entry(TABLE_ENTRIES - 1, 4'd15);
		load_entry(TABLE_ENTRIES / 2, 4'd0);
		load_entry(1023, 4'd9);
		load_entry(TABLE_ENTRIES, 4'd3);
		// minus pi lands on entry 0: fade from speaker 0 to 5
		play_sample(1'b1, 16'h8000, {1'b0, {(SAMPLE_BITS-1){1'b1}}});
		play_sample(1'b0, 16'h0000, {1'b1, {(SAMPLE_BITS-1){1'b0}}});
		// just under plus pi rounds past the last entry and wraps to 0: no fade
		play_sample(1'b1, 16'h7FFF, '1);
		play_sample(1'b0, 16'h5555, 24'h000001);
		// last entry: fade 5 -> 15
		play_sample(1'b1, AZ_BITS'(offset_for_index(TABLE_ENTRIES - 1) - 32768),
			{1'b0, {(SAMPLE_BITS-1){1'b1}}});
		// center entry: fade 15 -> 0, zero sample
		play_sample(1'b1, AZ_BITS'(offset_for_index(TABLE_ENTRIES / 2) - 32768), '0);
		play_sample(1'b0, 16'hAAAA, pick_sample());
		// overwrite a used entry and start a chunk on it
		load_entry(TABLE_ENTRIES / 2, 4'd10);
		play_sample(1'b1, AZ_BITS'(offset_for_index(TABLE_ENTRIES / 2) - 32768),
			pick_sample());
		play_sample(1'b0, AZ_BITS'($urandom), pick_sample());

		// Random phases: each rewrites the ramp step while idle, then streams
		// chunks of random length with table traffic between and inside them.
		for (p = 0; p < PHASES; p++) begin
			set_idling(p / 3);
			write_ramp(ramp_for_phase(p));
			stop_at = items_sent + ITEMS_PER_PHASE;
			while (items_sent < stop_at) begin
				if ($urandom_range(99) < 20) begin
					// table traffic between chunks; one in ten misses the table
					if ($urandom_range(9) == 0)
						load_entry($urandom_range(1023, TABLE_ENTRIES), SPK_BITS'($urandom));
					else
						load_entry($urandom_range(TABLE_ENTRIES - 1), SPK_BITS'($urandom));
				end else begin
					// Pick the chunk's azimuth only from loaded entries. A quarter
					// of the chunks reuse the last angle to keep the speaker.
					if ($urandom_range(3) == 0) begin
						az = last_az;
					end else begin
						w  = loaded_idx[$urandom_range(loaded_idx.size() - 1)];
						lo = offset_for_index(w);
						hi = (w == TABLE_ENTRIES - 1) ?
							offset_for_index(TABLE_ENTRIES) - 1 : offset_for_index(w + 1) - 1;
						// entry 0 is also reached from the band just below plus pi
						if (w == 0 && $urandom_range(1) == 1) begin
							lo = offset_for_index(TABLE_ENTRIES);
							hi = U_FULL;
						end
						az = AZ_BITS'($urandom_range(hi, lo) - 32768);
					end
					last_az = az;
					// mostly short chunks, now and then one long enough to
					// run the gain into its ceiling at the gentler ramp steps
					len = ($urandom_range(15) == 0) ? $urandom_range(300, 40) :
						$urandom_range(24, 1);
					play_sample(1'b1, az, pick_sample());
					repeat (len - 1) begin
						// drop an occasional table load into the middle of a chunk
						if ($urandom_range(19) == 0)
							load_entry($urandom_range(TABLE_ENTRIES - 1), SPK_BITS'($urandom));
						play_sample(1'b0, AZ_BITS'($urandom), pick_sample());
					end
				end
			end
		end

		drain();

		$display("Covered %0d table loads (%0d more outside the table) and %0d samples in %0d chunks",
			n_loads, n_stray, n_samples, n_chunks);
		$display("over %0d ramp step settings; %0d results carried a crossfade.",
			n_settings, fade_beats);
		if (mismatches == 0 && awaited == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
